// ===== hw/rtl/sm64_pkg.sv =====
package sm64_pkg;

  localparam int unsigned WordW = 64;
  localparam int unsigned HalfW = 32;
  localparam int unsigned OpW = 2;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned MaxTries = 256;
  localparam int unsigned TriesW = $clog2(MaxTries);

  localparam logic [WordW-1:0] MixMulA = 64'hBF58476D1CE4E5B9;
  localparam logic [WordW-1:0] MixMulB = 64'h94D049BB133111EB;
  localparam logic [WordW-1:0] GammaReset = 64'h9E3779B97F4A7C15;

  typedef logic [WordW-1:0] word_t;

  typedef enum logic [OpW-1:0] {
    OP_RAW   = 2'd0,
    OP_BELOW = 2'd1,
    OP_SEEK  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SEED   = 2'd0,
    REG_STREAM = 2'd1,
    REG_GAMMA  = 2'd2,
    REG_UNUSED = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    RET_SEED,
    RET_START,
    RET_DRAW
  } ret_t;

  typedef enum logic [3:0] {
    S_RST0,
    S_IDLE,
    S_MIX_A,
    S_MIX_AW,
    S_MIX_B,
    S_MIX_BW,
    S_SEED,
    S_START,
    S_LEFT,
    S_LEFT_W,
    S_DMUL,
    S_DMUL_W,
    S_DRAWN,
    S_DIV_W,
    S_OUT
  } state_t;

  // operation request/completion between sequencer and a shared unit
  typedef struct packed {
    logic  start;
    word_t a;
    word_t b;
  } unit_req_t;

  typedef struct packed {
    logic  done;
    word_t result;
  } unit_rsp_t;

endpackage

// ===== hw/rtl/sm64_if.sv =====
interface sm64_req_if;
  logic valid;
  logic ready;
  logic [sm64_pkg::OpW-1:0] operation;
  sm64_pkg::word_t bound;
  sm64_pkg::word_t new_counter;
  modport source (output valid, operation, bound, new_counter, input ready);
  modport sink (input valid, operation, bound, new_counter, output ready);
endinterface

interface sm64_rsp_if;
  logic valid;
  logic ready;
  sm64_pkg::word_t value;
  sm64_pkg::word_t counter_after;
  logic bad_bound;
  modport source (output valid, value, counter_after, bad_bound, input ready);
  modport sink (input valid, value, counter_after, bad_bound, output ready);
endinterface

interface sm64_cfg_if;
  logic valid;
  logic ready;
  logic [sm64_pkg::CfgIdxW-1:0] index;
  sm64_pkg::word_t data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/sm64_mul.sv =====
// Low 64 bits of a 64x64 product through one 32x32 multiplier, three passes.
module sm64_mul (
  input  logic                clk,
  input  logic                rst,
  input  sm64_pkg::unit_req_t req,
  output sm64_pkg::unit_rsp_t rsp
);

  logic [1:0] step;
  logic busy;
  sm64_pkg::word_t a;
  sm64_pkg::word_t b;
  sm64_pkg::word_t acc;
  logic done;
  logic [sm64_pkg::HalfW-1:0] ma;
  logic [sm64_pkg::HalfW-1:0] mb;
  logic [2*sm64_pkg::HalfW-1:0] prod;

  always_comb begin
    unique case (step)
      2'd0: begin
        ma = a[sm64_pkg::HalfW-1:0];
        mb = b[sm64_pkg::HalfW-1:0];
      end
      2'd1: begin
        ma = a[sm64_pkg::WordW-1:sm64_pkg::HalfW];
        mb = b[sm64_pkg::HalfW-1:0];
      end
      default: begin
        ma = a[sm64_pkg::HalfW-1:0];
        mb = b[sm64_pkg::WordW-1:sm64_pkg::HalfW];
      end
    endcase
    prod = ma * mb;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        if (step == 2'd2) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        step <= step + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      a <= req.a;
      b <= req.b;
    end else if (busy) begin
      if (step == 2'd0) begin
        acc <= prod;
      end else begin
        // cross terms only reach the upper half
        acc <= acc + {prod[sm64_pkg::HalfW-1:0], {sm64_pkg::HalfW{1'b0}}};
      end
    end
  end

  assign rsp.done = done;
  assign rsp.result = acc;

endmodule

// ===== hw/rtl/sm64_div.sv =====
// Remainder a mod b, restoring, one bit per cycle.
module sm64_div (
  input  logic                clk,
  input  logic                rst,
  input  sm64_pkg::unit_req_t req,
  output sm64_pkg::unit_rsp_t rsp
);

  localparam int unsigned CntW = $clog2(sm64_pkg::WordW);

  logic busy;
  logic done;
  logic [CntW-1:0] cnt;
  sm64_pkg::word_t num;
  sm64_pkg::word_t den;
  sm64_pkg::word_t rem;
  logic [sm64_pkg::WordW:0] trial;
  logic [sm64_pkg::WordW:0] diff;

  always_comb begin
    trial = {rem, num[sm64_pkg::WordW-1]};
    diff = trial - {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt <= '0;
      end else if (busy) begin
        if (cnt == CntW'(sm64_pkg::WordW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      num <= req.a;
      den <= req.b;
      rem <= '0;
    end else if (busy) begin
      num <= {num[sm64_pkg::WordW-2:0], 1'b0};
      // remainder stays below den, so the low word is enough
      if (!diff[sm64_pkg::WordW]) begin
        rem <= diff[sm64_pkg::WordW-1:0];
      end else begin
        rem <= trial[sm64_pkg::WordW-1:0];
      end
    end
  end

  assign rsp.done = done;
  assign rsp.result = rem;

endmodule

// ===== hw/rtl/counter_splitmix64_rng_below.sv =====
// Counter-based splitmix64 generator. Operations: raw draw, unbiased draw below
// a bound, and counter seek. Seed, stream id and gamma are written on the cfg
// channel (index 0, 1, 2; index 3 is ignored); any write clears the counter and
// recomputes the stream start, during which no item is taken; the same happens
// after reset. A pending register write takes priority over an item offered in
// the same cycle. A draw runs one 64-bit multiply and the two-multiply mixer on
// a single shared 32x32 multiplier (each 64-bit multiply: start, three passes,
// handoff). A bounded draw adds a remainder for the rejection threshold and one
// for the final reduction, and repeats the draw on rejection, at most 256 draws.
// Bound zero returns bad_bound with value 0. One item is in work at a time; the
// result waits in the output register.
module counter_splitmix64_rng_below (
  input  logic clk,
  input  logic rst,
  sm64_req_if.sink   req,
  sm64_rsp_if.source rsp,
  sm64_cfg_if.sink   cfg
);

  sm64_pkg::state_t state;
  sm64_pkg::state_t state_next;
  sm64_pkg::ret_t ret;
  sm64_pkg::word_t seed;
  sm64_pkg::word_t stream_id;
  sm64_pkg::word_t gamma;
  sm64_pkg::word_t counter;
  sm64_pkg::word_t start;
  sm64_pkg::word_t z;
  sm64_pkg::word_t leftover;
  sm64_pkg::word_t bound;
  sm64_pkg::word_t value;
  logic bad_bound;
  sm64_pkg::op_t op;
  logic [sm64_pkg::TriesW-1:0] tries;
  logic cfg_hit;
  logic req_acc;
  logic accept_draw;
  sm64_pkg::unit_req_t mul_req;
  sm64_pkg::unit_rsp_t mul_rsp;
  sm64_pkg::unit_req_t div_req;
  sm64_pkg::unit_rsp_t div_rsp;

  sm64_mul u_mul (.clk(clk), .rst(rst), .req(mul_req), .rsp(mul_rsp));
  sm64_div u_div (.clk(clk), .rst(rst), .req(div_req), .rsp(div_rsp));

  // hold the item while a register write is taken
  assign req.ready = (state == sm64_pkg::S_IDLE) && !cfg_hit;
  assign cfg.ready = (state == sm64_pkg::S_IDLE);
  assign req_acc = req.valid && req.ready;
  assign cfg_hit = cfg.valid && cfg.ready &&
                   (cfg.index != sm64_pkg::REG_UNUSED);
  assign accept_draw = (z >= leftover) ||
                       (tries == sm64_pkg::TriesW'(sm64_pkg::MaxTries - 1));

  assign rsp.valid = (state == sm64_pkg::S_OUT);
  assign rsp.value = value;
  assign rsp.counter_after = counter;
  assign rsp.bad_bound = bad_bound;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sm64_pkg::S_RST0;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mul_req = '0;
    div_req = '0;
    unique case (state)
      sm64_pkg::S_RST0: state_next = sm64_pkg::S_MIX_A;
      sm64_pkg::S_IDLE: begin
        if (cfg_hit) begin
          state_next = sm64_pkg::S_RST0;
        end else if (req_acc) begin
          unique case (sm64_pkg::op_t'(req.operation))
            sm64_pkg::OP_RAW: state_next = sm64_pkg::S_DMUL;
            sm64_pkg::OP_BELOW: begin
              if (req.bound == '0) begin
                state_next = sm64_pkg::S_OUT;
              end else begin
                state_next = sm64_pkg::S_LEFT;
              end
            end
            default: state_next = sm64_pkg::S_OUT;
          endcase
        end
      end
      sm64_pkg::S_MIX_A: begin
        mul_req.start = 1'b1;
        mul_req.a = z ^ (z >> 30);
        mul_req.b = sm64_pkg::MixMulA;
        state_next = sm64_pkg::S_MIX_AW;
      end
      sm64_pkg::S_MIX_AW: if (mul_rsp.done) state_next = sm64_pkg::S_MIX_B;
      sm64_pkg::S_MIX_B: begin
        mul_req.start = 1'b1;
        mul_req.a = z;
        mul_req.b = sm64_pkg::MixMulB;
        state_next = sm64_pkg::S_MIX_BW;
      end
      sm64_pkg::S_MIX_BW: begin
        if (mul_rsp.done) begin
          unique case (ret)
            sm64_pkg::RET_SEED:  state_next = sm64_pkg::S_SEED;
            sm64_pkg::RET_START: state_next = sm64_pkg::S_START;
            default:             state_next = sm64_pkg::S_DRAWN;
          endcase
        end
      end
      sm64_pkg::S_SEED:  state_next = sm64_pkg::S_MIX_A;
      sm64_pkg::S_START: state_next = sm64_pkg::S_IDLE;
      sm64_pkg::S_LEFT: begin
        div_req.start = 1'b1;
        div_req.a = '0 - bound;
        div_req.b = bound;
        state_next = sm64_pkg::S_LEFT_W;
      end
      sm64_pkg::S_LEFT_W: if (div_rsp.done) state_next = sm64_pkg::S_DMUL;
      sm64_pkg::S_DMUL: begin
        mul_req.start = 1'b1;
        mul_req.a = counter + 64'd1;
        mul_req.b = gamma;
        state_next = sm64_pkg::S_DMUL_W;
      end
      sm64_pkg::S_DMUL_W: if (mul_rsp.done) state_next = sm64_pkg::S_MIX_A;
      sm64_pkg::S_DRAWN: begin
        if (op == sm64_pkg::OP_RAW) begin
          state_next = sm64_pkg::S_OUT;
        end else if (accept_draw) begin
          div_req.start = 1'b1;
          div_req.a = z;
          div_req.b = bound;
          state_next = sm64_pkg::S_DIV_W;
        end else begin
          state_next = sm64_pkg::S_DMUL;
        end
      end
      sm64_pkg::S_DIV_W: if (div_rsp.done) state_next = sm64_pkg::S_OUT;
      sm64_pkg::S_OUT: if (rsp.ready) state_next = sm64_pkg::S_IDLE;
      default: state_next = sm64_pkg::S_RST0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= '0;
      stream_id <= '0;
      gamma <= sm64_pkg::GammaReset;
      counter <= '0;
      ret <= sm64_pkg::RET_SEED;
    end else begin
      unique case (state)
        sm64_pkg::S_RST0: begin
          z <= stream_id + gamma;
          ret <= sm64_pkg::RET_SEED;
          counter <= '0;
        end
        sm64_pkg::S_IDLE: begin
          if (cfg_hit) begin
            unique case (sm64_pkg::reg_idx_t'(cfg.index))
              sm64_pkg::REG_SEED:   seed <= cfg.data;
              sm64_pkg::REG_STREAM: stream_id <= cfg.data;
              default:              gamma <= cfg.data;
            endcase
          end else if (req_acc) begin
            op <= sm64_pkg::op_t'(req.operation);
            bound <= req.bound;
            value <= '0;
            bad_bound <= (sm64_pkg::op_t'(req.operation) == sm64_pkg::OP_BELOW) &&
                         (req.bound == '0);
            leftover <= '0;
            if (sm64_pkg::op_t'(req.operation) == sm64_pkg::OP_SEEK) begin
              counter <= req.new_counter;
            end
          end
        end
        sm64_pkg::S_MIX_AW: if (mul_rsp.done) z <= mul_rsp.result ^ (mul_rsp.result >> 27);
        sm64_pkg::S_MIX_BW: if (mul_rsp.done) z <= mul_rsp.result ^ (mul_rsp.result >> 31);
        sm64_pkg::S_SEED: begin
          z <= seed ^ z;
          ret <= sm64_pkg::RET_START;
        end
        sm64_pkg::S_START: start <= z;
        sm64_pkg::S_LEFT_W: begin
          if (div_rsp.done) begin
            leftover <= div_rsp.result;
            tries <= '0;
          end
        end
        sm64_pkg::S_DMUL_W: begin
          if (mul_rsp.done) begin
            z <= start + mul_rsp.result;
            counter <= counter + 64'd1;
            ret <= sm64_pkg::RET_DRAW;
          end
        end
        sm64_pkg::S_DRAWN: begin
          if (op == sm64_pkg::OP_RAW) begin
            value <= z;
          end else if (!accept_draw) begin
            tries <= tries + 1'b1;
          end
        end
        sm64_pkg::S_DIV_W: if (div_rsp.done) value <= div_rsp.result;
        default: ;
      endcase
    end
  end

  a_out_only_done: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> !mul_req.start && !div_req.start)
    else $error("result shown while a unit is started");

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.bad_bound |-> rsp.value == '0)
    else $error("bad bound with nonzero value");

  a_cfg_clears: assert property (@(posedge clk) disable iff (rst)
    cfg_hit |=> ##1 counter == '0)
    else $error("counter not cleared after register write");

  a_busy_after_item: assert property (@(posedge clk) disable iff (rst)
    req_acc |=> !req.ready)
    else $error("ready right after taking an item");

endmodule
